### rtl/uniform_grid_broadphase_assert.svh
// Assertion macros for the grid broadphase block.
`ifndef UNIFORM_GRID_BROADPHASE_ASSERT_SVH
`define UNIFORM_GRID_BROADPHASE_ASSERT_SVH
`ifndef SYNTHESIS
// Check that a condition implies a property from the next cycle on.
`define UGB_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
// Check that a condition implies a property in the same cycle.
`define UGB_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
`else
`define UGB_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`define UGB_ASSERT_NOW(label, clk, rst_n, cond, prop)
`endif
`endif

### rtl/ugb_pkg.sv
package ugb_pkg;

    localparam int NUM_BODIES_DEF = 32;
    localparam int GRID_COLS_DEF  = 64;
    localparam int GRID_ROWS_DEF  = 64;
    localparam int MAX_RESULTS    = 32;
    localparam int CELL_SIZE_W    = 13;
    localparam int COORD_W        = 12;
    localparam int SUM_W          = 13;
    localparam int ID_W           = 5;
    localparam logic [CELL_SIZE_W-1:0] CELL_SIZE_RST = 13'd32;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_QBODY  = 2'd2,
        ACT_QRECT  = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DIV,
        ST_WALK,
        ST_WDRAIN,
        ST_EMIT,
        ST_ACK
    } t_state;

    // Controller commands to the datapath.
    typedef struct packed {
        logic load;
        logic clr_step;
        logic div_start;
        logic walk_start;
        logic walk_step;
        logic emit_start;
        logic emit_step;
        logic out_load;
        logic out_ack;
    } t_cmd;

    // Datapath status back to the controller.
    typedef struct packed {
        logic clr_done;
        logic div_done;
        logic walk_done;
        logic emit_done;
    } t_stat;

endpackage

### rtl/ugb_datapath.sv
module ugb_datapath #(
    parameter int NUM_BODIES = ugb_pkg::NUM_BODIES_DEF,
    parameter int GRID_COLS  = ugb_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS  = ugb_pkg::GRID_ROWS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ugb_pkg::t_cmd                      i_cmd,
    output ugb_pkg::t_stat                     o_stat,
    input  logic [ugb_pkg::CELL_SIZE_W-1:0]    i_cell_size,
    input  logic [1:0]                         i_action,
    input  logic [ugb_pkg::ID_W-1:0]           i_body_id,
    input  logic [ugb_pkg::COORD_W-1:0]        i_rect_x,
    input  logic [ugb_pkg::COORD_W-1:0]        i_rect_y,
    input  logic [ugb_pkg::COORD_W-1:0]        i_rect_w,
    input  logic [ugb_pkg::COORD_W-1:0]        i_rect_h,
    output logic [1:0]                         o_action,
    output logic [ugb_pkg::ID_W-1:0]           o_hit_body,
    output logic                               o_found,
    output logic                               o_last,
    output logic                               o_cur_hit
);
    localparam int NUM_CELLS = GRID_COLS * GRID_ROWS;
    localparam int CW  = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int RW  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int AW  = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int BW  = $clog2(NUM_BODIES);
    localparam int SW  = ugb_pkg::SUM_W;
    localparam int DW  = ugb_pkg::CELL_SIZE_W;
    localparam int DCW = $clog2(SW + 1);
    localparam int NCW = $clog2(ugb_pkg::MAX_RESULTS + 1);

    // Latched item
    logic [1:0]       r_action;
    logic [BW:0]      r_self;
    logic [DW-1:0]    r_div;
    logic [SW-1:0]    r_num [4];
    logic [SW-1:0]    r_quo [4];
    logic [DW:0]      r_rem [4];
    logic [DCW-1:0]   r_dcnt;
    logic             r_ddone;
    logic [SW-1:0]    w_num [4];

    // Corner coordinates to divide
    assign w_num[0] = {1'b0, i_rect_x};
    assign w_num[1] = SW'({1'b0, i_rect_x} + {1'b0, i_rect_w});
    assign w_num[2] = {1'b0, i_rect_y};
    assign w_num[3] = SW'({1'b0, i_rect_y} + {1'b0, i_rect_h});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_self   <= (BW < ugb_pkg::ID_W && i_body_id >= ugb_pkg::ID_W'(NUM_BODIES)) ?
                        {1'b1, {BW{1'b0}}} : {1'b0, i_body_id[BW-1:0]};
            r_div    <= (i_cell_size == '0) ? DW'(1) : i_cell_size;
        end
    end

    // Four restoring dividers, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt  <= '0;
            r_ddone <= 1'b0;
        end else if (i_cmd.div_start) begin
            r_dcnt  <= DCW'(SW);
            r_ddone <= 1'b0;
        end else if (r_dcnt != '0) begin
            r_dcnt  <= r_dcnt - 1'b1;
            r_ddone <= (r_dcnt == DCW'(1));
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_div
        logic [DW:0] n_trial;
        assign n_trial = {r_rem[g][DW-1:0], r_num[g][SW-1]};
        always_ff @(posedge i_clk) begin
            if (i_cmd.div_start) begin
                r_rem[g] <= '0;
            end else if (r_dcnt != '0) begin
                r_num[g] <= {r_num[g][SW-2:0], 1'b0};
                if (n_trial >= {1'b0, r_div}) begin
                    r_rem[g] <= n_trial - {1'b0, r_div};
                    r_quo[g] <= {r_quo[g][SW-2:0], 1'b1};
                end else begin
                    r_rem[g] <= n_trial;
                    r_quo[g] <= {r_quo[g][SW-2:0], 1'b0};
                end
            end
            if (i_cmd.load)
                r_num[g] <= w_num[g];
        end
    end

    // Saturate cell indices
    logic [CW-1:0] w_c0, w_c1;
    logic [RW-1:0] w_r0, w_r1;
    assign w_c0 = (r_quo[0] >= SW'(GRID_COLS)) ? CW'(GRID_COLS - 1) : CW'(r_quo[0]);
    assign w_c1 = (r_quo[1] >= SW'(GRID_COLS)) ? CW'(GRID_COLS - 1) : CW'(r_quo[1]);
    assign w_r0 = (r_quo[2] >= SW'(GRID_ROWS)) ? RW'(GRID_ROWS - 1) : RW'(r_quo[2]);
    assign w_r1 = (r_quo[3] >= SW'(GRID_ROWS)) ? RW'(GRID_ROWS - 1) : RW'(r_quo[3]);

    // Cell walk counters and memory
    logic [NUM_BODIES-1:0] r_mem [NUM_CELLS];
    logic [NUM_BODIES-1:0] r_rdata;
    logic [CW-1:0]  r_col;
    logic [RW-1:0]  r_row;
    logic           r_wend;
    logic [AW-1:0]  r_clr;
    logic           r_rvalid;
    logic           r_wvalid;
    logic [AW-1:0]  r_raddr;
    logic [AW-1:0]  r_waddr;
    logic [NUM_BODIES-1:0] r_wdata;
    logic [NUM_BODIES-1:0] r_hits;
    logic [AW-1:0]  w_addr;
    logic [NUM_BODIES-1:0] w_self_bit;

    assign w_addr = AW'(r_row * GRID_COLS) + AW'(r_col);
    assign w_self_bit = r_self[BW] ? '0 : (NUM_BODIES'(1) << r_self[BW-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_wend <= 1'b0;
        end else begin
            if (i_cmd.clr_step)
                r_clr <= (r_clr == AW'(NUM_CELLS - 1)) ? '0 : r_clr + 1'b1;
            if (i_cmd.walk_start) begin
                r_col  <= w_c0;
                r_row  <= w_r0;
                r_wend <= 1'b0;
            end else if (i_cmd.walk_step) begin
                if (r_col == w_c1) begin
                    r_col <= w_c0;
                    r_row <= r_row + 1'b1;
                    r_wend <= (r_row == w_r1);
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    // Memory: read the walk cell, write back for insert or clear
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step)
            r_mem[r_clr] <= '0;
        else if (r_wvalid)
            r_mem[r_waddr] <= r_wdata;
        r_rdata <= r_mem[w_addr];
    end

    // Read pipe: registered read, then merge or write back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvalid <= 1'b0;
            r_wvalid <= 1'b0;
        end else begin
            r_rvalid <= i_cmd.walk_step;
            r_wvalid <= r_rvalid && (r_action == ugb_pkg::ACT_INSERT) && !r_self[BW];
        end
    end

    // Carry the cell address along with its read data
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_step)
            r_raddr <= w_addr;
        r_waddr <= r_raddr;
        r_wdata <= r_rdata | w_self_bit;
        if (i_cmd.walk_start)
            r_hits <= '0;
        else if (r_rvalid)
            r_hits <= r_hits | r_rdata;
    end

    // Emit scan: one body id per cycle while emit_step is set, ascending
    logic [BW:0]  r_scan;
    logic [NCW-1:0] r_cnt;
    logic [NUM_BODIES-1:0] w_hm;
    logic [NUM_BODIES-1:0] w_rest;
    logic w_cur;
    logic w_more;

    assign w_hm = (r_action == ugb_pkg::ACT_QBODY) ? (r_hits & ~w_self_bit) : r_hits;
    assign w_cur = w_hm[r_scan[BW-1:0]];
    assign w_rest = w_hm >> r_scan[BW-1:0];
    assign w_more = ((w_rest >> 1) != '0) && (r_scan < (BW+1)'(NUM_BODIES - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_start) begin
            r_scan <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.emit_step) begin
            r_scan <= r_scan + 1'b1;
            if (i_cmd.out_load)
                r_cnt <= r_cnt + 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ack) begin
            o_hit_body <= '0;
            o_found    <= 1'b0;
            o_last     <= 1'b1;
        end else if (i_cmd.out_load) begin
            o_hit_body <= ugb_pkg::ID_W'(r_scan[BW-1:0]);
            o_found    <= 1'b1;
            o_last     <= !w_more || (r_cnt == NCW'(ugb_pkg::MAX_RESULTS - 1));
        end
    end

    assign o_action           = r_action;
    assign o_cur_hit          = w_cur;
    assign o_stat.clr_done    = (r_clr == AW'(NUM_CELLS - 1));
    assign o_stat.div_done    = r_ddone;
    assign o_stat.walk_done   = r_wend;
    // emit_done: no hits, or current id is a hit and is the last to emit
    assign o_stat.emit_done   = (w_hm == '0) || (w_cur && (!w_more ||
                                (r_cnt == NCW'(ugb_pkg::MAX_RESULTS - 1))));
endmodule

### rtl/ugb_ctrl.sv
module ugb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    output logic            o_valid,
    input  logic            i_stall,
    input  logic [1:0]      i_cur_action,
    input  logic            i_cur_hit,
    input  ugb_pkg::t_stat  i_stat,
    output ugb_pkg::t_cmd   o_cmd,
    output logic            o_busy
);
    ugb_pkg::t_state r_state, n_state;
    logic r_ovalid;
    logic r_boot;
    logic w_free;
    logic w_in_acc;

    // Output slot is free when empty or taken this cycle
    assign w_free   = !r_ovalid || !i_stall;
    assign w_in_acc = i_valid && !o_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ugb_pkg::ST_IDLE:
                if (w_in_acc)
                    n_state = ugb_pkg::ST_DIV;
            // The clearing pass after reset acknowledges nothing
            ugb_pkg::ST_SWEEP:
                if (i_stat.clr_done)
                    n_state = r_boot ? ugb_pkg::ST_IDLE : ugb_pkg::ST_ACK;
            ugb_pkg::ST_DIV:
                if (i_stat.div_done)
                    n_state = (i_cur_action == ugb_pkg::ACT_CLEAR) ?
                              ugb_pkg::ST_SWEEP : ugb_pkg::ST_WALK;
            ugb_pkg::ST_WALK:
                if (i_stat.walk_done)
                    n_state = ugb_pkg::ST_WDRAIN;
            ugb_pkg::ST_WDRAIN:
                n_state = (i_cur_action == ugb_pkg::ACT_INSERT) ?
                          ugb_pkg::ST_ACK : ugb_pkg::ST_EMIT;
            ugb_pkg::ST_EMIT:
                if (i_stat.emit_done && w_free)
                    n_state = ugb_pkg::ST_IDLE;
            ugb_pkg::ST_ACK:
                if (w_free)
                    n_state = ugb_pkg::ST_IDLE;
            default:
                n_state = ugb_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ugb_pkg::ST_IDLE: begin
                o_cmd.load      = w_in_acc;
                o_cmd.div_start = w_in_acc;
            end
            ugb_pkg::ST_SWEEP:
                o_cmd.clr_step = 1'b1;
            ugb_pkg::ST_DIV:
                o_cmd.walk_start = i_stat.div_done;
            ugb_pkg::ST_WALK:
                o_cmd.walk_step = !i_stat.walk_done;
            ugb_pkg::ST_WDRAIN:
                o_cmd.emit_start = 1'b1;
            ugb_pkg::ST_EMIT: begin
                o_cmd.emit_step = w_free;
                o_cmd.out_load  = w_free && i_cur_hit;
                o_cmd.out_ack   = w_free && i_stat.emit_done && !i_cur_hit;
            end
            ugb_pkg::ST_ACK:
                o_cmd.out_ack = w_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ugb_pkg::ST_SWEEP;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load || o_cmd.out_ack)
                r_ovalid <= 1'b1;
            else if (!i_stall)
                r_ovalid <= 1'b0;
        end
    end

    // Track the clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_boot <= 1'b1;
        else if (r_state == ugb_pkg::ST_SWEEP && i_stat.clr_done)
            r_boot <= 1'b0;
    end

    assign o_stall = (r_state != ugb_pkg::ST_IDLE);
    assign o_valid = r_ovalid;
    assign o_busy  = r_boot;
endmodule

### rtl/uniform_grid_broadphase.sv
// Uniform grid broadphase.
// Input channel: i_valid / o_stall with action, body id and rectangle. Output
// channel: o_valid / i_stall with hit_body, found and last. Configuration:
// i_cfg_valid / o_cfg_ready writes cell_size; write it only while idle.
// Each item first runs four restoring dividers in parallel to turn rectangle
// corners into cell indices; inserts and queries then walk the covered cells
// at one grid memory read per cycle. Insert writes each cell back; queries
// OR the read masks. Clear sweeps all GRID_COLS*GRID_ROWS cells, one per cycle.
// Results leave from one output register: queries scan body ids one per
// cycle in ascending order, emitting each hit; clear and insert, or a query
// with no hit, give one acknowledgement with found low and last high.
// States run in order: divide, walk and drain, then an acknowledgement for an
// insert or the id scan for a query; a clear goes from the divide state to the
// sweep and then acknowledges.
// One item is in work at a time; the next is taken the cycle after the last
// result of the previous one is loaded.
// Reset clears cell_size to 32 and runs a clearing pass over GRID_COLS*GRID_ROWS
// cells (4096 by default) before the first item is accepted.
// A stall on the output holds the result register and pauses the scan.
module uniform_grid_broadphase #(
    parameter int NUM_BODIES = ugb_pkg::NUM_BODIES_DEF,
    parameter int GRID_COLS  = ugb_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS  = ugb_pkg::GRID_ROWS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [4:0]  i_body_id,
    input  logic [11:0] i_rect_x,
    input  logic [11:0] i_rect_y,
    input  logic [11:0] i_rect_w,
    input  logic [11:0] i_rect_h,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_hit_body,
    output logic        o_found,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [12:0] i_cfg_data
);
`include "uniform_grid_broadphase_assert.svh"

    ugb_pkg::t_cmd  w_cmd;
    ugb_pkg::t_stat w_stat;
    logic [12:0]    r_cell_size;
    logic [1:0]     w_cur_action;
    logic           w_busy;
    logic           w_cur_hit;

    // Hold the cell size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_cell_size <= ugb_pkg::CELL_SIZE_RST;
        else if (i_cfg_valid && o_cfg_ready)
            r_cell_size <= i_cfg_data;
    end
    assign o_cfg_ready = 1'b1;

    ugb_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .i_cur_action (w_cur_action),
        .i_cur_hit    (w_cur_hit),
        .i_stat       (w_stat),
        .o_cmd        (w_cmd),
        .o_busy       (w_busy)
    );

    ugb_datapath #(
        .NUM_BODIES (NUM_BODIES),
        .GRID_COLS  (GRID_COLS),
        .GRID_ROWS  (GRID_ROWS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cell_size (r_cell_size),
        .i_action    (i_action),
        .i_body_id   (i_body_id),
        .i_rect_x    (i_rect_x),
        .i_rect_y    (i_rect_y),
        .i_rect_w    (i_rect_w),
        .i_rect_h    (i_rect_h),
        .o_action    (w_cur_action),
        .o_hit_body  (o_hit_body),
        .o_found     (o_found),
        .o_last      (o_last),
        .o_cur_hit   (w_cur_hit)
    );

    `UGB_ASSERT_NOW(a_no_accept_in_boot, i_clk, i_rst_n, w_busy, o_stall)
    `UGB_ASSERT_NOW(a_ack_not_found, i_clk, i_rst_n, o_valid && !o_found, o_last)
    `UGB_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, w_cmd.out_load, o_valid && o_found)
endmodule
